// ===== hdl/sdppsm_pkg.sv =====
// Package for the SDP protocol-descriptor-list PSM parser.
// Holds SDP type codes, UUIDs, limits, the result struct and a header helper.
// No dependencies; sdppsm_core and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package sdppsm_pkg;

  localparam int MAX_VALUE_BYTES_DEF = 32;

  localparam logic [7:0]  T_SEQ8          = 8'h35;
  localparam logic [7:0]  T_SEQ16         = 8'h36;
  localparam logic [7:0]  T_SEQ32         = 8'h37;
  localparam logic [7:0]  T_UUID16        = 8'h19;
  localparam logic [15:0] UUID_L2CAP      = 16'h0100;
  localparam logic [15:0] UUID_AVDTP      = 16'h0019;
  localparam logic [31:0] MIN_ELEM_BYTES  = 32'd6;
  localparam logic [5:0]  MIN_VALUE_BYTES = 6'd2;
  localparam logic [15:0] MIN_VERSION_RST = 16'h0100;

  // Verdict of one parse step, handed from the core to the result register.
  typedef struct packed {
    logic        give;
    logic        found;
    logic [15:0] channel_psm;
    logic [15:0] avdtp_version;
  } res_t;

  // Number of length bytes that follow a sequence type byte, zero if bad.
  function automatic logic [2:0] seq_hdr_bytes(input logic [7:0] t);
    logic [2:0] h;
    h = 3'd0;
    if (t == T_SEQ8)  h = 3'd1;
    if (t == T_SEQ16) h = 3'd2;
    if (t == T_SEQ32) h = 3'd4;
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sdppsm_if.sv =====
// Handshake interfaces of the SDP protocol-descriptor-list PSM parser:
// byte input stream, result stream and the configuration write channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sdppsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [5:0] value_length;
  logic       last_byte;

  modport source (output valid, data_byte, value_length, last_byte, input ready);
  modport sink   (input valid, data_byte, value_length, last_byte, output ready);
endinterface

interface sdppsm_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] channel_psm;
  logic [15:0] avdtp_version;

  modport source (output valid, found, channel_psm, avdtp_version, input ready);
  modport sink   (input valid, found, channel_psm, avdtp_version, output ready);
endinterface

interface sdppsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sdppsm_core.sv =====
// Parse state and per-byte step logic of the SDP PSM parser.
// Depends on sdppsm_pkg for type codes, UUIDs and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module sdppsm_core #(
  parameter int MAX_VALUE_BYTES = sdppsm_pkg::MAX_VALUE_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic [5:0]        value_length,
  input  wire logic              last_byte,
  input  wire logic [15:0]       min_version,
  output sdppsm_pkg::res_t       res
);
  import sdppsm_pkg::*;

  localparam int CW = $clog2(MAX_VALUE_BYTES + 1);
  localparam int LW = (CW > 6) ? CW : 6;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_VALUE_BYTES);

  localparam logic [2:0] PH_OUTER_TYPE = 3'd0;
  localparam logic [2:0] PH_OUTER_LEN  = 3'd1;
  localparam logic [2:0] PH_INNER_TYPE = 3'd2;
  localparam logic [2:0] PH_INNER_LEN  = 3'd3;
  localparam logic [2:0] PH_ELEM       = 3'd4;

  logic [2:0]    parse_phase, parse_phase_next;
  logic [2:0]    header_bytes_left, header_bytes_left_next;
  logic [LW-1:0] bytes_consumed, bytes_consumed_next;
  logic [31:0]   element_length, element_length_next;
  logic [LW-1:0] element_position, element_position_next;
  logic          element_is_uuid16, element_is_uuid16_next;
  logic [15:0]   uuid_value, uuid_value_next;
  logic [15:0]   field_value, field_value_next;
  logic [15:0]   psm_seen, psm_seen_next;
  logic          psm_valid, psm_valid_next;
  logic [15:0]   version_seen, version_seen_next;
  logic          result_given, result_given_next;

  logic [LW:0]   len;
  logic [LW:0]   p1;
  logic [LW:0]   left;
  logic [LW:0]   q1;
  logic [2:0]    h;
  logic [2:0]    hl_dec;
  logic          at_end;
  logic          v_found;
  logic          v_miss;
  logic          done_chk;

  always_comb begin
    if (LW'(value_length) > MAX_LEN) begin
      len = {1'b0, MAX_LEN};
    end else begin
      len = (LW+1)'(value_length);
    end
    p1     = {1'b0, bytes_consumed} + 1'b1;
    q1     = {1'b0, element_position} + 1'b1;
    left   = (len > p1) ? (len - p1) : '0;
    at_end = last_byte || (p1 >= len);
    h      = seq_hdr_bytes(data_byte);
    hl_dec = header_bytes_left - 3'd1;

    parse_phase_next       = parse_phase;
    header_bytes_left_next = header_bytes_left;
    bytes_consumed_next    = bytes_consumed;
    element_length_next    = element_length;
    element_position_next  = element_position;
    element_is_uuid16_next = element_is_uuid16;
    uuid_value_next        = uuid_value;
    field_value_next       = field_value;
    psm_seen_next          = psm_seen;
    psm_valid_next         = psm_valid;
    version_seen_next      = version_seen;
    result_given_next      = result_given;
    v_miss                 = 1'b0;
    done_chk               = 1'b0;

    if (!result_given) begin
      bytes_consumed_next = p1[LW-1:0];
      case (parse_phase)
        PH_OUTER_TYPE: begin
          if ((value_length < MIN_VALUE_BYTES) || (h == 3'd0)) begin
            v_miss = 1'b1;
          end else begin
            header_bytes_left_next = h;
            parse_phase_next       = PH_OUTER_LEN;
          end
        end
        PH_OUTER_LEN: begin
          header_bytes_left_next = hl_dec;
          if (hl_dec == 3'd0) begin
            parse_phase_next = PH_INNER_TYPE;
          end
        end
        PH_INNER_TYPE: begin
          if (h == 3'd0) begin
            v_miss = 1'b1;
          end else begin
            header_bytes_left_next = h;
            element_length_next    = '0;
            parse_phase_next       = PH_INNER_LEN;
          end
        end
        PH_INNER_LEN: begin
          element_length_next    = {element_length[23:0], data_byte};
          header_bytes_left_next = hl_dec;
          if (hl_dec == 3'd0) begin
            if (element_length_next > 32'(left)) begin
              v_miss = 1'b1;
            end else if (element_length_next == 32'd0) begin
              done_chk         = 1'b1;
              parse_phase_next = PH_INNER_TYPE;
            end else begin
              element_position_next  = '0;
              element_is_uuid16_next = 1'b0;
              parse_phase_next       = PH_ELEM;
            end
          end
        end
        default: begin
          if (element_length >= MIN_ELEM_BYTES) begin
            if (element_position == LW'(0)) begin
              element_is_uuid16_next = (data_byte == T_UUID16);
            end else if (element_position == LW'(1)) begin
              uuid_value_next = {data_byte, 8'h00};
            end else if (element_position == LW'(2)) begin
              uuid_value_next = {uuid_value[15:8], data_byte};
            end else if (element_position == LW'(4)) begin
              field_value_next = {data_byte, 8'h00};
            end else if (element_position == LW'(5)) begin
              field_value_next = {field_value[15:8], data_byte};
              if (element_is_uuid16 && (uuid_value == UUID_L2CAP)) begin
                psm_seen_next  = field_value_next;
                psm_valid_next = 1'b1;
              end else if (element_is_uuid16 && (uuid_value == UUID_AVDTP)) begin
                version_seen_next = field_value_next;
              end
            end
          end
          element_position_next = q1[LW-1:0];
          if (32'(q1) >= element_length) begin
            done_chk         = 1'b1;
            parse_phase_next = PH_INNER_TYPE;
          end
        end
      endcase
    end

    v_found = done_chk && psm_valid_next && (version_seen_next >= min_version);

    res.give          = !result_given && (v_found || v_miss || at_end);
    res.found         = v_found;
    res.channel_psm   = v_found ? psm_seen_next : 16'h0000;
    res.avdtp_version = version_seen_next;
    if (res.give) begin
      result_given_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      parse_phase       <= PH_OUTER_TYPE;
      header_bytes_left <= '0;
      bytes_consumed    <= '0;
      element_length    <= '0;
      element_position  <= '0;
      element_is_uuid16 <= 1'b0;
      uuid_value        <= '0;
      field_value       <= '0;
      psm_seen          <= '0;
      psm_valid         <= 1'b0;
      version_seen      <= '0;
      result_given      <= 1'b0;
    end else if (step) begin
      parse_phase       <= parse_phase_next;
      header_bytes_left <= header_bytes_left_next;
      bytes_consumed    <= bytes_consumed_next;
      element_length    <= element_length_next;
      element_position  <= element_position_next;
      element_is_uuid16 <= element_is_uuid16_next;
      uuid_value        <= uuid_value_next;
      field_value       <= field_value_next;
      psm_seen          <= psm_seen_next;
      psm_valid         <= psm_valid_next;
      version_seen      <= version_seen_next;
      result_given      <= result_given_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sdp_protocol_list_psm_parser_unit.sv =====
// Top level of the SDP protocol-descriptor-list PSM parser.
// Depends on sdppsm_pkg, the interfaces in sdppsm_if.sv and sdppsm_core.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                                     Handshake
// din       in    data_byte[7:0] value_length[5:0] last_byte  valid/ready
// dout      out   found channel_psm[15:0] avdtp_version[15:0] valid/ready
// cfg       in    data[15:0] = min_protocol_version           valid/ready
//
// One byte is accepted per cycle unless a result is stalled; an accepted byte is
// held in the input register, and a result request it decides is written to the
// result register and presented from there.
// The per-byte parse step is one pass of compare and update logic between the
// input register and the result register: one byte a cycle unless a result stalls.
// rst is synchronous and active high; it clears the parse state and sets the
// minimum version to 0x0100. Only a byte that produces a result waits for a
// stalled result register; bytes that produce none keep flowing.

module sdp_protocol_list_psm_parser_unit #(
  parameter int MAX_VALUE_BYTES = sdppsm_pkg::MAX_VALUE_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  sdppsm_in_if.sink  din,
  sdppsm_out_if.source dout,
  sdppsm_cfg_if.sink cfg
);
  import sdppsm_pkg::*;

  // The configuration register. Writes must arrive only while the block is idle; the block does not enforce this.
  logic [15:0] min_version;

  // Input register holding one accepted byte request.
  logic        s1_valid;
  logic [7:0]  s1_data_byte;
  logic [5:0]  s1_value_length;
  logic        s1_last_byte;

  // Result register.
  logic        out_valid;
  logic        out_found;
  logic [15:0] out_psm;
  logic [15:0] out_version;

  res_t        res;
  logic        s1_adv;
  logic        step;
  logic        out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_version <= MIN_VERSION_RST;
    end else if (cfg.valid) begin
      min_version <= cfg.data;
    end
  end

  // The held byte moves on unless it produces a result that cannot be stored.
  assign out_free  = !out_valid || dout.ready;
  assign s1_adv    = !res.give || out_free;
  assign step      = s1_valid && s1_adv;
  assign din.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_data_byte    <= din.data_byte;
      s1_value_length <= din.value_length;
      s1_last_byte    <= din.last_byte;
    end
  end

  sdppsm_core #(
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (s1_data_byte),
    .value_length (s1_value_length),
    .last_byte    (s1_last_byte),
    .min_version  (min_version),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.give;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.give) begin
      out_found   <= res.found;
      out_psm     <= res.channel_psm;
      out_version <= res.avdtp_version;
    end
  end

  assign dout.valid         = out_valid;
  assign dout.found         = out_found;
  assign dout.channel_psm   = out_psm;
  assign dout.avdtp_version = out_version;

  // A not-found result always carries a zero PSM.
  a_miss_zero_psm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_psm == 16'h0000))
    else $error("not-found result with nonzero PSM");

  // A byte that decides a result is only stepped when the result register can take it.
  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (step && res.give) |-> out_free)
    else $error("result produced while result register is full");

  // Input is only held back by a waiting result behind a result-giving byte.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> (s1_valid && out_valid && !dout.ready && res.give))
    else $error("input stalled without a blocked result");

  // Reset restores the minimum version.
  a_cfg_reset: assert property (@(posedge clk)
    $past(rst) |-> (min_version == MIN_VERSION_RST))
    else $error("minimum version not restored by reset");

endmodule

`default_nettype wire
